[hw/rtl/rar_pkg.sv]
// Shared widths and word types for the fraction adder with gcd reduction.
package rar_pkg;

  localparam int IN_W      = 31;             // input field width
  localparam int OUT_W     = 63;             // sum and result width
  localparam int PROD_W    = 2 * IN_W;       // one cross product
  localparam int MUL_CNT_W = $clog2(IN_W);   // multiplier bit counter
  localparam int DIV_CNT_W = $clog2(OUT_W);  // divider bit counter
  localparam int SHF_W     = $clog2(OUT_W);  // gcd common-twos count

  typedef struct packed {
    logic [IN_W-1:0] first_num;
    logic [IN_W-1:0] first_den;
    logic [IN_W-1:0] second_num;
    logic [IN_W-1:0] second_den;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] sum_num;
    logic [OUT_W-1:0] sum_den;
  } out_word_t;

endpackage

[hw/rtl/rar_stream_if.sv]
// Valid/ready stream channel carrying one word per handshake.
interface rar_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/rar_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module rar_mul import rar_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   mcand,
  input  logic [IN_W-1:0]   mplier,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    mc;
  logic [IN_W-1:0]      mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        mc   <= PROD_W'(mcand);
        mp   <= mplier;
        prod <= '0;
      end else if (busy) begin
        if (mp[0]) begin
          prod <= prod + mc;
        end
        mc  <= mc << 1;
        mp  <= mp >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(IN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/rar_gcd.sv]
// Binary gcd: one shift or one subtract-and-shift per cycle.
module rar_gcd import rar_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [OUT_W-1:0] x,
  input  logic [OUT_W-1:0] y,
  output logic             done,
  output logic [OUT_W-1:0] g
);

  logic             busy;
  logic [OUT_W-1:0] a;
  logic [OUT_W-1:0] b;
  logic [SHF_W-1:0] k;
  logic [OUT_W:0]   diff;

  // borrow bit set means a < b
  assign diff = {1'b0, a} - {1'b0, b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        a    <= x;
        b    <= y;
        k    <= '0;
      end else if (busy) begin
        priority if (a == '0 || b == '0) begin
          g    <= (a | b) << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + 1'b1;
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (!diff[OUT_W]) begin
          a <= diff[OUT_W-1:0] >> 1;
        end else begin
          b <= (b - a) >> 1;
        end
      end
    end
  end

endmodule

[hw/rtl/rar_div.sv]
// Restoring divider, one quotient bit per cycle, MSB first.
module rar_div import rar_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [OUT_W-1:0] dividend,
  input  logic [OUT_W-1:0] divisor,
  output logic             done,
  output logic [OUT_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [OUT_W-1:0]     rem;
  logic [OUT_W-1:0]     dsr;
  logic [OUT_W:0]       trial;
  logic                 fits;

  // quot shifts dividend bits out at the top and quotient bits in at the bottom
  assign trial = {rem, quot[OUT_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= divisor;
        quot <= dividend;
      end else if (busy) begin
        rem  <= fits ? OUT_W'(trial - {1'b0, dsr}) : trial[OUT_W-1:0];
        quot <= {quot[OUT_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(OUT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/rational_add_reduce.sv]
// Top level: adds two fractions and reduces the sum by its gcd.
//
// Usage:
//   in_ch  (sink)   one word = first_num, first_den, second_num, second_den,
//                   each 31-bit unsigned; a word is taken when valid & ready.
//   out_ch (source) one word = sum_num, sum_den, 63-bit unsigned, the sum
//                   (a*d + c*b)/(b*d) divided through by its gcd.
//   One result word for every input word, in order.
//   A zero sum numerator gives 0/1; a zero denominator input gives 1/0 (or 0/1
//   when the sum numerator is zero as well).
// From accept to result valid, a word passes, in order, through:
//   the three bit-serial 31x31 products and the sum,
//   the binary gcd (one shift or subtract per step, data dependent),
//   the two bit-serial divisions by the gcd (run in parallel),
//   and the control states that hand off between them.
// One word at a time: in_ch.ready is high only while idle, so a word is
// taken only after the previous one has reached the output register.
// The finished word sits in an output register, so the next input word
// is taken while the previous result still waits on a stalled receiver;
// a new result then waits until that register has been taken.
// Reset (rst, synchronous) drops any word in flight and clears out valid.
module rational_add_reduce import rar_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  rar_stream_if.sink   in_ch,
  rar_stream_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_GCD,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  // captured operands
  logic [IN_W-1:0] n1, d1, n2, d2;

  // unit handshakes
  logic mul_start, gcd_start, div_start;
  logic mul_a_done, mul_b_done, mul_c_done;
  logic gcd_done, div_num_done, div_den_done;

  logic [PROD_W-1:0] prod_a, prod_b, prod_c;
  logic [OUT_W-1:0]  num, den, g;
  logic [OUT_W-1:0]  q_num, q_den;
  logic [OUT_W-1:0]  res_num, res_den;

  logic      out_valid;
  out_word_t out_word;

  assign in_ch.ready    = (state == S_IDLE);
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_word;

  // n1*d2, n2*d1, d1*d2 run side by side
  rar_mul u_mul_a (
    .clk(clk), .rst(rst), .start(mul_start),
    .mcand(n1), .mplier(d2), .done(mul_a_done), .prod(prod_a)
  );

  rar_mul u_mul_b (
    .clk(clk), .rst(rst), .start(mul_start),
    .mcand(n2), .mplier(d1), .done(mul_b_done), .prod(prod_b)
  );

  rar_mul u_mul_c (
    .clk(clk), .rst(rst), .start(mul_start),
    .mcand(d1), .mplier(d2), .done(mul_c_done), .prod(prod_c)
  );

  rar_gcd u_gcd (
    .clk(clk), .rst(rst), .start(gcd_start),
    .x(num), .y(den), .done(gcd_done), .g(g)
  );

  rar_div u_div_num (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(num), .divisor(g), .done(div_num_done), .quot(q_num)
  );

  rar_div u_div_den (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(den), .divisor(g), .done(div_den_done), .quot(q_den)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_start <= 1'b0;
      gcd_start <= 1'b0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      gcd_start <= 1'b0;
      div_start <= 1'b0;

      // receiver takes the held word
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            n1        <= in_ch.payload.first_num;
            d1        <= in_ch.payload.first_den;
            n2        <= in_ch.payload.second_num;
            d2        <= in_ch.payload.second_den;
            mul_start <= 1'b1;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          // all three products finish on the same cycle
          if (mul_c_done) begin
            num       <= OUT_W'(prod_a) + OUT_W'(prod_b);
            den       <= OUT_W'(prod_c);
            gcd_start <= 1'b1;
            state     <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            if (g == '0) begin
              // sum numerator and denominator both zero
              res_num <= '0;
              res_den <= OUT_W'(1);
              state   <= S_OUT;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_num_done) begin
            res_num <= q_num;
            res_den <= q_den;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          // wait for a free output register
          if (!out_valid || out_ch.ready) begin
            out_word.sum_num <= res_num;
            out_word.sum_den <= res_den;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // product units only report while the sequencer waits on them
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    (mul_a_done || mul_b_done || mul_c_done) |->
      (state == S_MUL && mul_a_done && mul_b_done && mul_c_done))
    else $error("multiplier done out of step");

  a_gcd_done_in_gcd: assert property (@(posedge clk) disable iff (rst)
    gcd_done |-> state == S_GCD)
    else $error("gcd done outside gcd phase");

  a_div_in_step: assert property (@(posedge clk) disable iff (rst)
    div_num_done == div_den_done)
    else $error("dividers out of step");

  a_no_div_by_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (g != '0))
    else $error("division by zero gcd");

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ch.ready) |=> state == S_OUT)
    else $error("result overwrote a held word");

endmodule

[tb/rational_add_reduce_test.sv]
// Testbench for rational_add_reduce: fraction sums checked against a gcd-reduced prediction.
`timescale 1ns / 1ps

module rational_add_reduce_test;
  import rar_pkg::*;

  localparam logic [IN_W-1:0] FMAX   = {IN_W{1'b1}};  // largest 31-bit field
  localparam int              SETTLE = 300;           // beyond the worst word latency

  // Expected-sum tracker: predicts the reduced sum of every accepted operand
  // word and checks result words against the oldest prediction.
  class sum_tracker;
    out_word_t pending_sums[$];
    int        fail_cnt;

    function new();
      fail_cnt = 0;
    endfunction

    // Cross-multiplied sum over the denominator product, divided through by
    // the Euclid gcd. A zero gcd (both values zero) gives 0/1.
    function out_word_t reduced_sum(in_word_t w);
      bit [63:0] n1, d1, n2, d2, num, den, a, b, r;
      out_word_t s;
      n1  = w.first_num;
      d1  = w.first_den;
      n2  = w.second_num;
      d2  = w.second_den;
      num = n1 * d2 + n2 * d1;
      den = d1 * d2;
      a   = num;
      b   = den;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      if (a == 0) begin
        s.sum_num = '0;
        s.sum_den = OUT_W'(1);
      end else begin
        s.sum_num = OUT_W'(num / a);
        s.sum_den = OUT_W'(den / a);
      end
      return s;
    endfunction

    function void note_operands(in_word_t w);
      pending_sums.push_back(reduced_sum(w));
    endfunction

    function void check_sum(out_word_t got);
      out_word_t exp_sum;
      if (pending_sums.size() == 0) begin
        $display("%0t unexpected result word %0d/%0d", $time, got.sum_num, got.sum_den);
        fail_cnt++;
        return;
      end
      exp_sum = pending_sums.pop_front();
      if (got.sum_num !== exp_sum.sum_num) begin
        $display("%0t sum_num: expected %0d, got %0d", $time, exp_sum.sum_num, got.sum_num);
        fail_cnt++;
      end
      if (got.sum_den !== exp_sum.sum_den) begin
        $display("%0t sum_den: expected %0d, got %0d", $time, exp_sum.sum_den, got.sum_den);
        fail_cnt++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rar_stream_if #(.payload_t(in_word_t))  in_ch ();
  rar_stream_if #(.payload_t(out_word_t)) out_ch ();

  rational_add_reduce uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sum_tracker board = new();

  // Idle mix of the current phase, in percent.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_left     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Runaway guard, far past the slowest legal run (~4 ms).
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random single-cycle stalls, now and then a long one so that a
  // finished word sits in the output register while the next is in flight.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(99) < recv_stall_pct) begin
      out_ch.ready <= 1'b0;
      if ($urandom_range(15) == 0) stall_left = $urandom_range(1, SETTLE);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Both channels are watched on the same edge; values read here are the
  // ones that held before the edge, so the handshake is race free.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) board.note_operands(in_ch.payload);
      if (out_ch.valid && out_ch.ready) board.check_sum(out_ch.payload);
    end
  end

  // Offer one operand word, with an optional gap first. valid stays high on
  // return, so back-to-back words never lower and raise it in one step.
  task automatic send_operands(in_word_t w);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(1, SETTLE) : $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold the sender off until every predicted sum has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_sums.size() != 0) @(posedge clk);
  endtask

  // Random operands: full-range, small values that reduce often, power-of-two
  // denominators, and pairs that share a common factor.
  function automatic in_word_t random_operands();
    in_word_t   w;
    logic [IN_W-1:0] f;
    case ($urandom_range(4))
      0, 1: begin
        w.first_num  = IN_W'($urandom);
        w.first_den  = IN_W'($urandom);
        w.second_num = IN_W'($urandom);
        w.second_den = IN_W'($urandom);
        if (w.first_den == 0) w.first_den = 1;
        if (w.second_den == 0) w.second_den = 1;
      end
      2: begin
        w.first_num  = IN_W'($urandom_range(0, 60));
        w.first_den  = IN_W'($urandom_range(1, 60));
        w.second_num = IN_W'($urandom_range(0, 60));
        w.second_den = IN_W'($urandom_range(1, 60));
      end
      3: begin
        w.first_num  = IN_W'($urandom);
        w.first_den  = FMAX & (IN_W'(1) << $urandom_range(0, IN_W - 1));
        w.second_num = IN_W'($urandom);
        w.second_den = FMAX & (IN_W'(1) << $urandom_range(0, IN_W - 1));
      end
      default: begin
        f            = IN_W'($urandom_range(1, 30000));
        w.first_num  = f * IN_W'($urandom_range(0, 60000));
        w.first_den  = f * IN_W'($urandom_range(1, 60000));
        w.second_num = f * IN_W'($urandom_range(0, 60000));
        w.second_den = f * IN_W'($urandom_range(1, 60000));
        if (w.first_den == 0) w.first_den = f;
        if (w.second_den == 0) w.second_den = f;
      end
    endcase
    // Occasional zero numerator on either side.
    if ($urandom_range(19) == 0) w.first_num = '0;
    if ($urandom_range(19) == 0) w.second_num = '0;
    return w;
  endfunction

  initial begin
    int phase_send[4];
    int phase_recv[4];
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words, no idling: field extremes and the documented corners.
    send_operands('{31'd0, 31'd1, 31'd0, 31'd1});          // zero sum -> 0/1
    send_operands('{31'd0, FMAX, 31'd0, 31'd7});           // zero sum, big den
    send_operands('{FMAX, FMAX, FMAX, FMAX});              // 2/1
    send_operands('{FMAX, 31'd1, FMAX, 31'd1});            // largest whole sum
    send_operands('{31'd1, FMAX, 31'd1, FMAX});            // largest denominator
    send_operands('{FMAX, 31'd1, 31'd1, FMAX});            // largest numerator
    send_operands('{31'd1, 31'd2, 31'd1, 31'd3});          // 5/6, nothing to reduce
    send_operands('{31'd1, 31'd2, 31'd1, 31'd2});          // reduces to 1/1
    send_operands('{31'd1, 31'd3, 31'd1, 31'd6});          // 1/2
    send_operands('{31'd1, 31'd1 << 30, 31'd1, 31'd1 << 30});  // power-of-two gcd
    send_operands('{31'd1 << 30, 31'd1 << 30, 31'd0, 31'd1});  // 1/1
    send_operands('{31'h5555_5555, 31'h2AAA_AAAA, 31'h2AAA_AAAA, 31'h5555_5555});
    send_operands('{FMAX, 31'd2147483629, 31'd2147483629, FMAX});
    send_operands('{31'd6, 31'd9, 31'd10, 31'd15});        // common factors
    // Zero denominators, outside the normal range: nonzero sum gives 1/0,
    // a zero sum gives 0/1.
    send_operands('{31'd3, 31'd0, 31'd0, 31'd5});
    send_operands('{31'd0, 31'd0, 31'd0, 31'd0});
    send_operands('{31'd0, 31'd0, 31'd5, 31'd7});
    send_operands('{31'd5, 31'd0, 31'd5, 31'd0});
    send_operands('{FMAX, 31'd0, FMAX, FMAX});
    wait_for_results();

    // Random phases: none, sender idle, receiver stalls, both.
    phase_send = '{0, 58, 0, 37};
    phase_recv = '{0, 0, 58, 37};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      for (int i = 0; i < 100; i++) send_operands(random_operands());
      wait_for_results();
    end

    recv_stall_pct = 0;
    repeat (SETTLE) @(posedge clk);
    if (board.pending_sums.size() != 0) begin
      $display("%0t %0d expected sums never arrived", $time, board.pending_sums.size());
      board.fail_cnt++;
    end
    if (board.fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
